// ===== rtl/ssil_pkg.sv =====
package ssil_pkg;

   localparam int KEY_W     = 31;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 6;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMIT     = 2'd3;

   typedef struct packed {
      logic                 command;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [KEY_W-1:0]     out_key;
      logic [PAYLOAD_W-1:0] out_payload;
      logic                 last;
      logic [COUNT_W-1:0]   count;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DRAIN
   } cell_op_type;

endpackage

// ===== rtl/ssil_cell.sv =====
module ssil_cell
   import ssil_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cell_op_type op,
   input  entry_type   new_entry,
   input  entry_type   left_entry,
   input  logic        left_keep,
   input  entry_type   right_entry,
   output entry_type   cur_entry,
   output logic        keep
);

   logic                 valid_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   entry_type            entry_in;

   assign cur_entry = '{valid: valid_ff, key: key_ff, payload: payload_ff};

   // An entry with a key less than or equal to the new one stays where it is,
   // which keeps equal keys in arrival order.
   assign keep = valid_ff && (key_ff <= new_entry.key);

   always_comb begin
      entry_in = cur_entry;
      case (op)
         CELL_INSERT: begin
            if (!keep) begin
               entry_in = left_keep ? new_entry : left_entry;
            end
         end
         CELL_DRAIN: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = cur_entry;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= entry_in.key;
      payload_ff <= entry_in.payload;
   end

endmodule

// ===== rtl/stable_sorted_insert_list.sv =====
// Sorted list of (key, payload) entries held in a row of compare-and-shift
// cells, ascending by key, equal keys in arrival order.
// Input channel: an item is taken at a rising edge with start high and busy
// low. Command insert places the entry unless the list is full; command drain
// reads the whole list out and empties it.
// Result channel: rsp_strobe marks a result for exactly one cycle; the
// receiver cannot stall it.
// Insert and drain results: an insert answers in the cycle after it is taken
// and busy stays low, so inserts go one per cycle. A drain holds busy high
// until its last entry is given and gives one entry per cycle; draining_ff is
// set when the drain is taken, then the result register takes each entry from
// cell zero as the cells shift toward cell zero once per cycle, which sets
// that rate. A drain of an empty list answers in the next cycle with busy low.
// Reset: synchronous, clears the valid flag of every cell, the count and
// any drain in progress. The list starts empty.
module stable_sorted_insert_list
   import ssil_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff,    count_in;
   logic          draining_ff, draining_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_item_ff,   rsp_item_in;

   cell_op_type   op;
   entry_type     new_entry;
   entry_type     cell_entry [DEPTH];
   logic          cell_keep  [DEPTH];
   logic          accept;
   logic          full;

   assign busy       = draining_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   assign accept    = start && !draining_ff;
   assign full      = (count_ff == CW'(DEPTH));
   assign new_entry = '{valid: 1'b1, key: req_item.key, payload: req_item.payload};

   always_comb begin
      if (draining_ff) begin
         op = CELL_DRAIN;
      end else if (accept && (req_item.command == CMD_INSERT) && !full) begin
         op = CELL_INSERT;
      end else begin
         op = CELL_HOLD;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_keep;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_keep  = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_next
         assign right_entry = cell_entry[i+1];
      end

      ssil_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .cur_entry   (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      draining_in   = draining_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '0;

      if (draining_ff) begin
         // Cell zero always holds the next entry while a drain runs.
         rsp_strobe_in           = 1'b1;
         rsp_item_in.status      = ST_EMIT;
         rsp_item_in.out_key     = cell_entry[0].key;
         rsp_item_in.out_payload = cell_entry[0].payload;
         rsp_item_in.last        = !cell_entry[1].valid;
         draining_in             = cell_entry[1].valid;
      end else if (accept) begin
         if (req_item.command == CMD_INSERT) begin
            rsp_strobe_in    = 1'b1;
            rsp_item_in.last = 1'b1;
            if (full) begin
               rsp_item_in.status = ST_FULL;
               rsp_item_in.count  = COUNT_W'(count_ff);
            end else begin
               count_in           = count_ff + CW'(1);
               rsp_item_in.status = ST_INSERTED;
               rsp_item_in.count  = COUNT_W'(count_in);
            end
         end else if (count_ff == '0) begin
            rsp_strobe_in      = 1'b1;
            rsp_item_in.status = ST_EMPTY;
            rsp_item_in.last   = 1'b1;
         end else begin
            count_in    = '0;
            draining_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         draining_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         draining_ff   <= draining_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// ===== rtl/ssil_checker.sv =====
module ssil_checker
   import ssil_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   // An insert is answered in the very next cycle with a single result.
   a_insert_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.command == CMD_INSERT) |=>
         rsp_strobe && rsp_item.last &&
         ((rsp_item.status == ST_INSERTED) || (rsp_item.status == ST_FULL)))
      else $error("insert not answered in the next cycle");

   // A drain ends only with the result that carries last.
   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_item.last && (rsp_item.status == ST_EMIT))
      else $error("drain ended without a final entry");

   // While entries are read out, more must follow until last is shown.
   a_drain_cont: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) |-> rsp_strobe && (rsp_item.status == ST_EMIT)
         && !rsp_item.last)
      else $error("gap or early last in drain");

   // Status results carry no entry; emitted entries report an empty list.
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         ((rsp_item.status == ST_EMIT) && (rsp_item.count == '0)) ||
         ((rsp_item.status != ST_EMIT) && (rsp_item.out_key == '0) &&
          (rsp_item.out_payload == '0) && rsp_item.last))
      else $error("result fields inconsistent with status");

endmodule

bind stable_sorted_insert_list ssil_checker u_ssil_checker (.*);
